// File: src/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants of the sorted cursor table
// request and result layouts, operation codes, parameter defaults
// ----------------------------------------------------------------------------
package sct_pkg;

  // parameter defaults
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int POS_BITS_DEF    = 32;

  // operation codes
  localparam logic [2:0] MODE_CLEAR  = 3'd0;
  localparam logic [2:0] MODE_SEARCH = 3'd1;
  localparam logic [2:0] MODE_ADD    = 3'd2;
  localparam logic [2:0] MODE_REMOVE = 3'd3;
  localparam logic [2:0] MODE_INS    = 3'd4;
  localparam logic [2:0] MODE_DEL    = 3'd5;
  localparam logic [2:0] MODE_READ   = 3'd6;
  // no operation
  localparam logic [2:0] MODE_NONE   = 3'd7;

  // one request
  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] position;
    logic [31:0] mark;
    logic [5:0]  index;
    logic [31:0] delta;
  } in_req_t;

  // one result
  typedef struct packed {
    logic        ok;
    logic [6:0]  slot;
    logic [6:0]  count;
    logic [31:0] entry_position;
    logic [31:0] entry_mark;
  } out_res_t;

endpackage

// File: src/sorted_cursor_table_core.sv
// ----------------------------------------------------------------------------
// sorted_cursor_table_core: sorted table of cursor entries
// position/mark pairs kept in ascending position order in one memory
// ----------------------------------------------------------------------------
// usage:
//   a request is taken when start is high and busy is low; busy stays high
//   until the result has been issued. each request gives one result, shown
//   on out_result for exactly one cycle with out_valid high; the receiver
//   cannot stall it, so it must take the result in that cycle.
// steps per request (n = entry count):
//   clear sets the count to zero; read fetches one entry; out of range or unknown mode fail
//   search and add run a binary search, one memory probe per step (at most log2(n)+1 probes)
//   add then moves the tail above the slot up and writes the new entry, or appends at the end
//   remove moves the tail down over the removed entry; no move when the last entry is removed
//   adjust insertion / deletion: one entry read-modify-write per cycle over all n entries
// the entry memory has a single read port, one read issued per cycle, with the
// read data registered and available in the cycle after the read is issued.
// one request at a time; the next may be taken at the edge that ends the result cycle.
// reset clears the entry count and the control state; the memory content is
// not cleared and entries at or above the count are never read.
// ----------------------------------------------------------------------------
module sorted_cursor_table_core #(
  parameter int MAX_ENTRIES = sct_pkg::MAX_ENTRIES_DEF,
  parameter int POS_BITS    = sct_pkg::POS_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  sct_pkg::in_req_t  in_req,
  output logic              out_valid,
  output sct_pkg::out_res_t out_result
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int DW = 2 * POS_BITS;
  localparam int EW = POS_BITS + 33;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SRCH, S_SCMP, S_SDONE, S_SHU, S_RMV, S_ADJ, S_RDW
  } state_t;

  // saturating shift up after an insertion
  function automatic logic [POS_BITS-1:0] grow(input logic [POS_BITS-1:0] v,
                                               input logic [POS_BITS-1:0] pt,
                                               input logic [31:0] d);
    logic [EW-1:0] s;
    s = EW'(v) + EW'(d);
    if (v <= pt) return v;
    else if (s > EW'({POS_BITS{1'b1}})) return {POS_BITS{1'b1}};
    else return s[POS_BITS-1:0];
  endfunction

  // shift down after a deletion, clamped at the edit point
  function automatic logic [POS_BITS-1:0] shrink(input logic [POS_BITS-1:0] v,
                                                 input logic [POS_BITS-1:0] pt,
                                                 input logic [31:0] d);
    logic [EW-1:0] s;
    s = EW'(v) - EW'(d);
    if (v <= pt) return v;
    else if (EW'(v - pt) > EW'(d)) return s[POS_BITS-1:0];
    else return pt;
  endfunction

  function automatic logic [6:0] to7(input logic [CW-1:0] v);
    logic [CW+6:0] t;
    t = {7'd0, v};
    return t[6:0];
  endfunction

  function automatic logic [31:0] to32(input logic [POS_BITS-1:0] v);
    logic [POS_BITS+31:0] t;
    t = {32'd0, v};
    return t[31:0];
  endfunction

  function automatic sct_pkg::out_res_t mk_res(input logic ok,
                                               input logic [6:0] slot,
                                               input logic [CW-1:0] cnt,
                                               input logic [POS_BITS-1:0] p,
                                               input logic [POS_BITS-1:0] m);
    sct_pkg::out_res_t r;
    r.ok             = ok;
    r.slot           = slot;
    r.count          = to7(cnt);
    r.entry_position = to32(p);
    r.entry_mark     = to32(m);
    return r;
  endfunction

  // registers
  state_t            state_r, state_nxt;
  sct_pkg::in_req_t  req_r, req_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [CW-1:0]     mid_r, mid_nxt;
  logic [CW-1:0]     slot_r, slot_nxt;
  logic              found_r, found_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     wa_r, wa_nxt;
  logic [CW-1:0]     kcnt_r, kcnt_nxt;
  logic [POS_BITS-1:0] last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  sct_pkg::out_res_t out_r, out_nxt;

  // memory ports
  logic [DW-1:0]     mem [MAX_ENTRIES];
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic [DW-1:0]     mem_wd;
  logic [DW-1:0]     mem_rd_r;

  // request fields at storage width
  logic [POS_BITS+31:0] pos_ext, mark_ext;
  logic [POS_BITS-1:0]  key_pos, key_mark;
  logic [CW+5:0]        idx_ext;
  logic [POS_BITS-1:0]  rd_pos, rd_mark, np, nm;
  logic [CW:0]          mid_sum;

  assign pos_ext  = {{POS_BITS{1'b0}}, req_r.position};
  assign mark_ext = {{POS_BITS{1'b0}}, req_r.mark};
  assign key_pos  = pos_ext[POS_BITS-1:0];
  assign key_mark = mark_ext[POS_BITS-1:0];
  assign idx_ext  = {{CW{1'b0}}, req_r.index};
  assign rd_pos   = mem_rd_r[DW-1:POS_BITS];
  assign rd_mark  = mem_rd_r[POS_BITS-1:0];
  assign mid_sum  = ({1'b0, lo_r} + {1'b0, hi_r}) >> 1;

  // adjusted entry for the edit passes
  always_comb begin
    if (req_r.mode == sct_pkg::MODE_INS) begin
      np = grow(rd_pos, key_pos, req_r.delta);
      nm = grow(rd_mark, key_pos, req_r.delta);
    end else begin
      np = shrink(rd_pos, key_pos, req_r.delta);
      nm = shrink(rd_mark, key_pos, req_r.delta);
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    slot_nxt      = slot_r;
    found_nxt     = found_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = pend_r;
    wa_nxt        = wa_r;
    kcnt_nxt      = kcnt_r;
    last_nxt      = last_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_wa        = wa_r;
    mem_wd        = mem_rd_r;
    mem_re        = 1'b0;
    mem_ra        = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (req_r.mode)
          sct_pkg::MODE_CLEAR: begin
            cnt_nxt       = '0;
            out_valid_nxt = 1'b1;
            out_nxt       = mk_res(1'b1, 7'd0, '0, '0, '0);
            state_nxt     = S_IDLE;
          end
          sct_pkg::MODE_SEARCH, sct_pkg::MODE_ADD: begin
            lo_nxt    = '0;
            hi_nxt    = cnt_r;
            state_nxt = S_SRCH;
          end
          sct_pkg::MODE_REMOVE: begin
            if (idx_ext < (CW+6)'(cnt_r)) begin
              ptr_nxt   = idx_ext[CW-1:0] + CW'(1);
              pend_nxt  = 1'b0;
              state_nxt = S_RMV;
            end else begin
              out_valid_nxt = 1'b1;
              out_nxt       = mk_res(1'b0, {1'b0, req_r.index}, cnt_r, '0, '0);
              state_nxt     = S_IDLE;
            end
          end
          sct_pkg::MODE_INS, sct_pkg::MODE_DEL: begin
            ptr_nxt   = '0;
            pend_nxt  = 1'b0;
            kcnt_nxt  = '0;
            state_nxt = S_ADJ;
          end
          sct_pkg::MODE_READ: begin
            if (idx_ext < (CW+6)'(cnt_r)) begin
              mem_re    = 1'b1;
              mem_ra    = idx_ext[AW-1:0];
              state_nxt = S_RDW;
            end else begin
              out_valid_nxt = 1'b1;
              out_nxt       = mk_res(1'b0, {1'b0, req_r.index}, cnt_r, '0, '0);
              state_nxt     = S_IDLE;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            out_nxt       = mk_res(1'b0, 7'd0, cnt_r, '0, '0);
            state_nxt     = S_IDLE;
          end
        endcase
      end
      // binary search probe
      S_SRCH: begin
        if (lo_r < hi_r) begin
          mem_re    = 1'b1;
          mem_ra    = mid_sum[AW-1:0];
          mid_nxt   = mid_sum[CW-1:0];
          state_nxt = S_SCMP;
        end else begin
          found_nxt = 1'b0;
          slot_nxt  = lo_r;
          state_nxt = S_SDONE;
        end
      end
      S_SCMP: begin
        if (rd_pos == key_pos) begin
          found_nxt = 1'b1;
          slot_nxt  = mid_r;
          state_nxt = S_SDONE;
        end else if (rd_pos < key_pos) begin
          lo_nxt    = mid_r + CW'(1);
          state_nxt = S_SRCH;
        end else begin
          hi_nxt    = mid_r;
          state_nxt = S_SRCH;
        end
      end
      S_SDONE: begin
        if (req_r.mode == sct_pkg::MODE_SEARCH || found_r ||
            cnt_r == CW'(MAX_ENTRIES)) begin
          out_valid_nxt = 1'b1;
          out_nxt       = mk_res(found_r && req_r.mode == sct_pkg::MODE_SEARCH,
                                 to7(slot_r), cnt_r, '0, '0);
          state_nxt     = S_IDLE;
        end else begin
          ptr_nxt   = cnt_r;
          pend_nxt  = 1'b0;
          state_nxt = S_SHU;
        end
      end
      // move the tail up by one, then place the new entry
      S_SHU: begin
        if (pend_r) begin
          mem_we = 1'b1;
        end
        if (ptr_r > slot_r) begin
          mem_re   = 1'b1;
          mem_ra   = AW'(ptr_r - CW'(1));
          wa_nxt   = ptr_r[AW-1:0];
          ptr_nxt  = ptr_r - CW'(1);
          pend_nxt = 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          mem_we        = 1'b1;
          mem_wa        = slot_r[AW-1:0];
          mem_wd        = {key_pos, key_mark};
          cnt_nxt       = cnt_r + CW'(1);
          out_valid_nxt = 1'b1;
          out_nxt       = mk_res(1'b1, to7(slot_r), cnt_r + CW'(1), '0, '0);
          state_nxt     = S_IDLE;
        end
      end
      // move the tail down by one over the removed entry
      S_RMV: begin
        if (pend_r) begin
          mem_we = 1'b1;
        end
        if (ptr_r < cnt_r) begin
          mem_re   = 1'b1;
          mem_ra   = ptr_r[AW-1:0];
          wa_nxt   = AW'(ptr_r - CW'(1));
          ptr_nxt  = ptr_r + CW'(1);
          pend_nxt = 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          cnt_nxt       = cnt_r - CW'(1);
          out_valid_nxt = 1'b1;
          out_nxt       = mk_res(1'b1, {1'b0, req_r.index}, cnt_r - CW'(1), '0, '0);
          state_nxt     = S_IDLE;
        end
      end
      // edit pass: adjust each entry, deletion also drops repeated positions
      S_ADJ: begin
        if (pend_r) begin
          mem_wd = {np, nm};
          if (req_r.mode == sct_pkg::MODE_INS) begin
            mem_we = 1'b1;
          end else if (kcnt_r == '0 || np != last_r) begin
            mem_we   = 1'b1;
            mem_wa   = kcnt_r[AW-1:0];
            last_nxt = np;
            kcnt_nxt = kcnt_r + CW'(1);
          end
        end
        if (ptr_r < cnt_r) begin
          mem_re   = 1'b1;
          mem_ra   = ptr_r[AW-1:0];
          wa_nxt   = ptr_r[AW-1:0];
          ptr_nxt  = ptr_r + CW'(1);
          pend_nxt = 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          if (req_r.mode == sct_pkg::MODE_DEL) begin
            cnt_nxt = kcnt_r;
          end
          out_valid_nxt = 1'b1;
          out_nxt       = mk_res(1'b1, 7'd0,
                                 (req_r.mode == sct_pkg::MODE_DEL) ? kcnt_r : cnt_r,
                                 '0, '0);
          state_nxt     = S_IDLE;
        end
      end
      S_RDW: begin
        out_valid_nxt = 1'b1;
        out_nxt       = mk_res(1'b1, {1'b0, req_r.index}, cnt_r, rd_pos, rd_mark);
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r   <= req_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    slot_r  <= slot_nxt;
    found_r <= found_nxt;
    ptr_r   <= ptr_nxt;
    wa_r    <= wa_nxt;
    kcnt_r  <= kcnt_nxt;
    last_r  <= last_nxt;
    out_r   <= out_nxt;
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_r <= mem[mem_ra];
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  // checks
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result issued while a request is still in work");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_res_past: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy))
    else $error("result without a request in work");

endmodule
